// ===== hw/rtl/fcca_pkg.sv =====
// shared constants and widths for the floor and ceiling cast address block
package fcca_pkg;

  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int DEF_TEX_SIZE      = 64;
  localparam int DEF_CAMERA_HEIGHT = 240;
  localparam int DEF_FADE_DISTANCE = 16;

  // brightness floor, 0.08 in Q0.8 truncated
  localparam logic [7:0] SHADE_MIN = 8'd20;

  // internal widths, sized for the largest screen and camera settings
  localparam int PW    = 14;  // horizon row and row distance
  localparam int NUMW  = 13;  // signed height numerator
  localparam int DNW   = 28;  // magnitude of numerator times 65536
  localparam int DW    = 29;  // signed row distance Q.16
  localparam int DIRW  = 30;  // signed ray scaled by screen width
  localparam int XW    = 45;  // signed world offset before the width divide
  localparam int QW    = 46;  // signed quotient after the width divide
  localparam int WW    = 47;  // signed world coordinate

  // register stages in the constant divider
  localparam int CDIV_LAT = 4;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] REG_EYE_X       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_EYE_Y       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LEFT_RAY_X  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LEFT_RAY_Y  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RIGHT_RAY_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RIGHT_RAY_Y = 3'd5;
  localparam logic [CFG_AW-1:0] REG_VIEW_PITCH  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_EYE_HEIGHT  = 3'd7;

endpackage

// ===== hw/rtl/floor_ceiling_cast_address.sv =====
// top level of the floor and ceiling cast address pipeline
//
//  channel   handshake        fields
//  --------  ---------------  ------------------------------------------------
//  config    cfg_we           cfg_addr, cfg_data
//  pixel in  start & !busy    pixel_row, pixel_col
//  result    done (1 cycle)   on_floor, depth_valid, cell_x, cell_y, texel_u,
//                             texel_v, shade
//
// one item enters every cycle; each result leaves after its item has passed through
// the 28-stage depth divider and the 4-stage reciprocal width and fade divides
// busy stays low; results are in order and cannot be stalled by the receiver
// rst is synchronous and clears the valid chain and the configuration registers to their reset values
module floor_ceiling_cast_address import fcca_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TEX_SIZE      = DEF_TEX_SIZE,
  parameter int CAMERA_HEIGHT = DEF_CAMERA_HEIGHT,
  parameter int FADE_DISTANCE = DEF_FADE_DISTANCE
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic [8:0]               pixel_row,
  input  logic [9:0]               pixel_col,
  output logic                     done,
  output logic                     on_floor,
  output logic                     depth_valid,
  output logic signed [15:0]       cell_x,
  output logic signed [15:0]       cell_y,
  output logic [5:0]               texel_u,
  output logic [5:0]               texel_v,
  output logic [7:0]               shade
);

  // configuration registers
  logic [23:0]        eye_x, eye_y;
  logic signed [15:0] left_ray_x, left_ray_y, right_ray_x, right_ray_y;
  logic signed [9:0]  view_pitch;
  logic signed [10:0] eye_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x       <= '0;
      eye_y       <= '0;
      left_ray_x  <= 16'sd16384;
      left_ray_y  <= '0;
      right_ray_x <= 16'sd16384;
      right_ray_y <= '0;
      view_pitch  <= '0;
      eye_height  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EYE_X:       eye_x       <= cfg_data;
        REG_EYE_Y:       eye_y       <= cfg_data;
        REG_LEFT_RAY_X:  left_ray_x  <= cfg_data[15:0];
        REG_LEFT_RAY_Y:  left_ray_y  <= cfg_data[15:0];
        REG_RIGHT_RAY_X: right_ray_x <= cfg_data[15:0];
        REG_RIGHT_RAY_Y: right_ray_y <= cfg_data[15:0];
        REG_VIEW_PITCH:  view_pitch  <= cfg_data[9:0];
        REG_EYE_HEIGHT:  eye_height  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic in_take;
  assign in_take = start & ~busy;

  // stage 1: horizon, layer, numerator, ray directions
  logic signed [PW-1:0]   hz, rowe, p_s;
  logic                   flr_c;
  logic signed [NUMW-1:0] num_c;
  logic [NUMW-1:0]        num_mag;
  logic signed [DIRW-1:0] dirx_c, diry_c;
  logic signed [16:0]     dfx, dfy;
  logic signed [10:0]     col_s;

  always_comb begin
    hz    = PW'(SCREEN_HEIGHT / 2) + PW'(view_pitch);
    rowe  = PW'({1'b0, pixel_row});
    flr_c = rowe > hz;
    p_s   = flr_c ? rowe - hz : hz - rowe;
    num_c = flr_c ? NUMW'(CAMERA_HEIGHT) + NUMW'(eye_height)
                  : NUMW'(CAMERA_HEIGHT) - NUMW'(eye_height);
    num_mag = num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
    col_s = $signed({1'b0, pixel_col});
    dfx   = 17'(right_ray_x) - 17'(left_ray_x);
    dfy   = 17'(right_ray_y) - 17'(left_ray_y);
    dirx_c = DIRW'(left_ray_x) * DIRW'(SCREEN_WIDTH) + DIRW'(dfx) * DIRW'(col_s);
    diry_c = DIRW'(left_ray_y) * DIRW'(SCREEN_WIDTH) + DIRW'(dfy) * DIRW'(col_s);
  end

  logic                   s1_vld, s1_flr, s1_zero, s1_neg;
  logic [DNW-1:0]         s1_num;
  logic [PW-1:0]          s1_p;
  logic signed [DIRW-1:0] s1_dirx, s1_diry;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= in_take;
  end
  always_ff @(posedge clk) begin
    s1_flr  <= flr_c;
    s1_zero <= (p_s == '0);
    s1_neg  <= num_c[NUMW-1];
    s1_num  <= DNW'({num_mag, 16'b0});
    s1_p    <= p_s;
    s1_dirx <= dirx_c;
    s1_diry <= diry_c;
  end

  // depth divider: |num| * 65536 / p
  localparam int SW1 = 3 + 2 * DIRW;
  logic                   d1_vld;
  logic [0:0][DNW-1:0]    d1_quo;
  logic [0:0]             d1_nz;
  logic [SW1-1:0]         d1_side;

  fcca_div #(.NW(DNW), .DVW(PW), .LANES(1), .SW(SW1)) u_depth_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s1_vld),
    .in_num   (s1_num),
    .in_den   (s1_p),
    .in_side  ({s1_flr, s1_zero, s1_neg, s1_dirx, s1_diry}),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_nz   (d1_nz),
    .out_side (d1_side)
  );

  // stage: signed distance
  logic                   s2_vld, s2_flr, s2_zero;
  logic signed [DW-1:0]   s2_d;
  logic signed [DIRW-1:0] s2_dirx, s2_diry;
  logic [DNW-1:0]         d1_q;
  assign d1_q = d1_quo[0];

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= d1_vld;
  end
  always_ff @(posedge clk) begin
    s2_flr  <= d1_side[SW1-1];
    s2_zero <= d1_side[SW1-2] | d1_nz[0] & 1'b0;
    s2_d    <= d1_side[SW1-3] ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
    s2_dirx <= d1_side[2*DIRW-1:DIRW];
    s2_diry <= d1_side[DIRW-1:0];
  end

  // stage: partial products of distance times ray
  logic                   s3_vld, s3_flr, s3_zero;
  logic signed [44:0]     s3_xlo, s3_ylo, s3_xhi, s3_yhi;
  logic signed [20:0]     s3_ds;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    s3_flr  <= s2_flr;
    s3_zero <= s2_zero;
    s3_xlo  <= 45'(s2_d) * 45'($signed({1'b0, s2_dirx[14:0]}));
    s3_ylo  <= 45'(s2_d) * 45'($signed({1'b0, s2_diry[14:0]}));
    s3_xhi  <= 45'(s2_d) * 45'($signed(s2_dirx[DIRW-1:15]));
    s3_yhi  <= 45'(s2_d) * 45'($signed(s2_diry[DIRW-1:15]));
    s3_ds   <= 21'(s2_d >>> 8);
  end

  // stage: full product, floor by 16384
  logic                 s4_vld, s4_flr, s4_zero;
  logic signed [XW-1:0] s4_x, s4_y;
  logic signed [20:0]   s4_ds;
  logic signed [59:0]   px, py;

  always_comb begin
    px = (60'(s3_xhi) <<< 15) + 60'(s3_xlo);
    py = (60'(s3_yhi) <<< 15) + 60'(s3_ylo);
  end

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else     s4_vld <= s3_vld;
  end
  always_ff @(posedge clk) begin
    s4_flr  <= s3_flr;
    s4_zero <= s3_zero;
    s4_x    <= XW'(px >>> 14);
    s4_y    <= XW'(py >>> 14);
    s4_ds   <= s3_ds;
  end

  // floored divides by screen width for both axes and by fade distance for shade
  logic signed [XW-1:0]  cd_qx, cd_qy;
  logic signed [20:0]    cd_qs;
  logic [CDIV_LAT-1:0]   cd_vld, cd_flr, cd_zero;

  fcca_cdiv #(.NW(XW), .DEN(SCREEN_WIDTH)) u_div_x (
    .clk     (clk),
    .in_num  (s4_x),
    .out_quo (cd_qx)
  );

  fcca_cdiv #(.NW(XW), .DEN(SCREEN_WIDTH)) u_div_y (
    .clk     (clk),
    .in_num  (s4_y),
    .out_quo (cd_qy)
  );

  fcca_cdiv #(.NW(21), .DEN(FADE_DISTANCE)) u_div_fade (
    .clk     (clk),
    .in_num  (s4_ds),
    .out_quo (cd_qs)
  );

  always_ff @(posedge clk) begin
    if (rst) cd_vld <= '0;
    else     cd_vld <= {cd_vld[CDIV_LAT-2:0], s4_vld};
  end
  always_ff @(posedge clk) begin
    cd_flr  <= {cd_flr[CDIV_LAT-2:0], s4_flr};
    cd_zero <= {cd_zero[CDIV_LAT-2:0], s4_zero};
  end

  // stage: floored signed quotients
  logic                 s6_vld, s6_flr, s6_zero;
  logic signed [QW-1:0] s6_qx, s6_qy, s6_qs;

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else     s6_vld <= cd_vld[CDIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    s6_flr  <= cd_flr[CDIV_LAT-1];
    s6_zero <= cd_zero[CDIV_LAT-1];
    s6_qx   <= QW'(cd_qx);
    s6_qy   <= QW'(cd_qy);
    s6_qs   <= QW'(cd_qs);
  end

  // stage: world coordinates and shade
  logic                 s7_vld, s7_flr, s7_zero;
  logic signed [WW-1:0] s7_wx, s7_wy;
  logic [7:0]           s7_shade;

  always_ff @(posedge clk) begin
    if (rst) s7_vld <= 1'b0;
    else     s7_vld <= s6_vld;
  end
  always_ff @(posedge clk) begin
    s7_flr  <= s6_flr;
    s7_zero <= s6_zero;
    s7_wx   <= $signed(WW'(eye_x)) + WW'(s6_qx);
    s7_wy   <= $signed(WW'(eye_y)) + WW'(s6_qy);
    if (s6_qs > QW'(256 - 20))  s7_shade <= SHADE_MIN;
    else if (s6_qs < QW'(1))    s7_shade <= 8'd255;
    else                        s7_shade <= 8'(9'd256 - 9'(s6_qs));
  end

  // output stage: truncate toward zero, saturate cell, mask texel
  function automatic logic [15:0] cell_of(input logic signed [WW-1:0] w);
    logic [WW-1:0] mag;
    logic [30:0]   cm;
    mag = w[WW-1] ? WW'(-w) : WW'(w);
    cm  = mag[WW-1:16];
    if (!w[WW-1]) return (cm > 31'd32767) ? 16'h7fff : cm[15:0];
    else          return (cm > 31'd32768) ? 16'h8000 : 16'(-cm[15:0]);
  endfunction

  function automatic logic [5:0] tex_of(input logic signed [WW-1:0] w);
    logic [WW-1:0] mag;
    logic [23:0]   prod;
    logic [8:0]    t;
    mag  = w[WW-1] ? WW'(-w) : WW'(w);
    prod = 24'(mag[15:0]) * 24'(TEX_SIZE);
    t    = w[WW-1] ? 9'(-{1'b0, prod[23:16]}) : {1'b0, prod[23:16]};
    t    = t & 9'(TEX_SIZE - 1);
    return t[5:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s7_vld;
  end
  always_ff @(posedge clk) begin
    on_floor    <= s7_flr;
    depth_valid <= ~s7_zero;
    if (s7_zero) begin
      cell_x  <= '0;
      cell_y  <= '0;
      texel_u <= '0;
      texel_v <= '0;
      shade   <= SHADE_MIN;
    end else begin
      cell_x  <= cell_of(s7_wx);
      cell_y  <= cell_of(s7_wy);
      texel_u <= tex_of(s7_wx);
      texel_v <= tex_of(s7_wy);
      shade   <= s7_shade;
    end
  end

endmodule

// ===== hw/rtl/fcca_div.sv =====
// pipelined dividers: restoring divider for a variable divisor, reciprocal divider for a constant
module fcca_div import fcca_pkg::*; #(
  parameter int NW    = DNW,
  parameter int DVW   = PW,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic [LANES-1:0][NW-1:0]       in_num,
  input  logic [LANES-1:0][DVW-1:0]      in_den,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_vld,
  output logic [LANES-1:0][NW-1:0]       out_quo,
  output logic [LANES-1:0]               out_nz,
  output logic [SW-1:0]                  out_side
);

  logic                      vld  [0:NW];
  logic [LANES-1:0][NW-1:0]  nq   [0:NW];
  logic [LANES-1:0][DVW-1:0] rm   [0:NW];
  logic [LANES-1:0][DVW-1:0] den  [0:NW];
  logic [SW-1:0]             side [0:NW];

  assign vld[0]  = in_vld;
  assign nq[0]   = in_num;
  assign rm[0]   = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [LANES-1:0][NW-1:0]  nq_next;
    logic [LANES-1:0][DVW-1:0] rm_next;

    always_comb begin
      logic [DVW:0] cat;
      logic         ge;
      for (int l = 0; l < LANES; l++) begin
        cat = {rm[s][l], nq[s][l][NW-1]};
        ge  = (cat >= {1'b0, den[s][l]});
        rm_next[l] = ge ? DVW'(cat - {1'b0, den[s][l]}) : cat[DVW-1:0];
        // numerator bits shift out the top, quotient bits shift in below
        nq_next[l] = {nq[s][l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      nq[s+1]   <= nq_next;
      rm[s+1]   <= rm_next;
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign out_vld  = vld[NW];
  assign out_quo  = nq[NW];
  assign out_side = side[NW];
  for (genvar l = 0; l < LANES; l++) begin : g_nz
    assign out_nz[l] = (rm[NW][l] != '0);
  end

endmodule

module fcca_cdiv import fcca_pkg::*; #(
  parameter int NW  = XW,
  parameter int DEN = DEF_SCREEN_WIDTH
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] in_num,
  output logic signed [NW-1:0] out_quo
);

  localparam int DVW  = $clog2(DEN + 1);
  localparam int K    = NW + DVW;
  localparam int KW   = K + 1;
  localparam int AL   = (NW + 1) / 2;
  localparam int AH   = NW - AL;
  localparam int ML   = (KW + 1) / 2;
  localparam int MH   = KW - ML;
  localparam int PRW  = NW + KW;
  localparam int PLLW = AL + ML;
  localparam int PLHW = AL + MH;
  localparam int PHLW = AH + ML;
  localparam int PHHW = AH + MH;
  localparam logic [KW-1:0] POW_K = KW'(1) << K;
  localparam logic [KW-1:0] RECIP = (POW_K + KW'(DEN - 1)) / KW'(DEN);

  // a negative numerator is biased so the magnitude divide rounds up
  logic          a_neg;
  logic [NW-1:0] a_mag;

  always_ff @(posedge clk) begin
    a_neg <= in_num[NW-1];
    a_mag <= in_num[NW-1] ? NW'(-in_num) + NW'(DEN - 1) : NW'(in_num);
  end

  // partial products of magnitude and reciprocal
  logic            b_neg;
  logic [PLLW-1:0] pp00;
  logic [PLHW-1:0] pp01;
  logic [PHLW-1:0] pp10;
  logic [PHHW-1:0] pp11;

  always_ff @(posedge clk) begin
    b_neg <= a_neg;
    pp00  <= PLLW'(a_mag[AL-1:0]) * PLLW'(RECIP[ML-1:0]);
    pp01  <= PLHW'(a_mag[AL-1:0]) * PLHW'(RECIP[KW-1:ML]);
    pp10  <= PHLW'(a_mag[NW-1:AL]) * PHLW'(RECIP[ML-1:0]);
    pp11  <= PHHW'(a_mag[NW-1:AL]) * PHHW'(RECIP[KW-1:ML]);
  end

  logic           c_neg;
  logic [PRW-1:0] c_outer, c_inner;

  always_ff @(posedge clk) begin
    c_neg   <= b_neg;
    c_outer <= (PRW'(pp11) << (AL + ML)) + PRW'(pp00);
    c_inner <= (PRW'(pp10) << AL) + (PRW'(pp01) << ML);
  end

  logic          d_neg;
  logic [NW-1:0] d_quo;

  always_ff @(posedge clk) begin
    d_neg <= c_neg;
    d_quo <= NW'((c_outer + c_inner) >> K);
  end

  assign out_quo = d_neg ? -$signed(d_quo) : $signed(d_quo);

endmodule

// ===== hw/rtl/fcca_checker.sv =====
// port-level checks for the floor and ceiling cast address block
module fcca_checker import fcca_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               on_floor,
  input logic               depth_valid,
  input logic signed [15:0] cell_x,
  input logic signed [15:0] cell_y,
  input logic [5:0]         texel_u,
  input logic [5:0]         texel_v,
  input logic [7:0]         shade
);

  localparam int LAT = 39;

  // the pipeline takes an item every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted item comes out a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing");

  // horizon items carry the blank address and the far brightness
  a_horizon: assert property (@(posedge clk) disable iff (rst)
    done && !depth_valid |-> !on_floor && cell_x == 16'sd0 && cell_y == 16'sd0 &&
                             texel_u == 6'd0 && texel_v == 6'd0 && shade == SHADE_MIN)
    else $error("horizon item not blanked");

  // brightness never drops below the floor
  a_shade_min: assert property (@(posedge clk) disable iff (rst)
    done |-> shade >= SHADE_MIN)
    else $error("shade below minimum");

endmodule

bind floor_ceiling_cast_address fcca_checker u_fcca_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .on_floor    (on_floor),
  .depth_valid (depth_valid),
  .cell_x      (cell_x),
  .cell_y      (cell_y),
  .texel_u     (texel_u),
  .texel_v     (texel_v),
  .shade       (shade)
);
